// ===== design/mcpg_pkg.sv =====
// Shared types and constants for the midpoint circle point generator.
// Used by every module of the block; depends on nothing.
package mcpg_pkg;

    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 11;
    localparam int PIX_BITS    = COORD_BITS + 2;
    localparam int DEC_BITS    = RADIUS_BITS + 3;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int PT_BITS     = 3;

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Kind of work handed from the front end to the point emitter.
    typedef enum logic [1:0] {
        CMD_AXIS,
        CMD_OCTANT,
        CMD_DONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [COORD_BITS-1:0]   cx;
        logic [COORD_BITS-1:0]   cy;
        logic [RADIUS_BITS-1:0]  ox;
        logic [RADIUS_BITS-1:0]  oy;
    } cmd_t;

    // Status of the command queue as seen by its producer and consumer.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ===== design/mcpg_front.sv =====
// Front end: accepts input items, runs the midpoint decision update and
// classifies each item into a command for the emitter. Depends on mcpg_pkg.
module mcpg_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [mcpg_pkg::COORD_BITS-1:0]  center_x,
    input  logic [mcpg_pkg::COORD_BITS-1:0]  center_y,
    input  logic [mcpg_pkg::RADIUS_BITS-1:0] radius,
    input  mcpg_pkg::q_status_t            q_status,
    output logic                           push,
    output mcpg_pkg::cmd_t                 push_cmd
);
    import mcpg_pkg::*;

    logic [COORD_BITS-1:0]       held_cx_reg, held_cx_next;
    logic [COORD_BITS-1:0]       held_cy_reg, held_cy_next;
    logic [RADIUS_BITS-1:0]      offset_x_reg, offset_x_next;
    logic [RADIUS_BITS-1:0]      offset_y_reg, offset_y_next;
    logic signed [DEC_BITS-1:0]  dec_reg, dec_next;
    logic                        active_reg, active_next;

    logic                        step_ok;
    logic [RADIUS_BITS-1:0]      xn;
    logic [RADIUS_BITS-1:0]      yn;
    logic signed [DEC_BITS-1:0]  diff;
    logic signed [DEC_BITS-1:0]  dec_step;
    logic signed [DEC_BITS-1:0]  dec_start;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // One iteration of the midpoint update on the held state.
    always_comb
    begin
        step_ok   = active_reg && (offset_y_reg > offset_x_reg);
        xn        = offset_x_reg + RADIUS_BITS'(1);
        yn        = dec_reg[DEC_BITS-1] ? offset_y_reg : offset_y_reg - RADIUS_BITS'(1);
        diff      = $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, xn})
                  - $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, yn});
        dec_step  = dec_reg[DEC_BITS-1]
                  ? dec_reg + $signed({{(DEC_BITS-RADIUS_BITS-1){1'b0}}, xn, 1'b1})
                  : dec_reg + (diff <<< 1) + DEC_BITS'(1);
        dec_start = DEC_BITS'(1) - $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, radius});
    end

    // Next state and the command pushed for the accepted item.
    always_comb
    begin
        held_cx_next  = held_cx_reg;
        held_cy_next  = held_cy_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        dec_next      = dec_reg;
        active_next   = active_reg;
        push_cmd.kind = CMD_DONE;
        push_cmd.cx   = held_cx_reg;
        push_cmd.cy   = held_cy_reg;
        push_cmd.ox   = xn;
        push_cmd.oy   = yn;
        if (op == OP_START)
        begin
            push_cmd.kind = CMD_AXIS;
            push_cmd.cx   = center_x;
            push_cmd.cy   = center_y;
            push_cmd.ox   = '0;
            push_cmd.oy   = radius;
            if (push)
            begin
                held_cx_next  = center_x;
                held_cy_next  = center_y;
                offset_x_next = '0;
                offset_y_next = radius;
                dec_next      = dec_start;
                active_next   = 1'b1;
            end
        end
        else if (step_ok)
        begin
            push_cmd.kind = CMD_OCTANT;
            if (push)
            begin
                offset_x_next = xn;
                offset_y_next = yn;
                dec_next      = dec_step;
            end
        end
    end

    // Circle state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cx_reg  <= '0;
            held_cy_reg  <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            dec_reg      <= '0;
            active_reg   <= 1'b0;
        end
        else
        begin
            held_cx_reg  <= held_cx_next;
            held_cy_reg  <= held_cy_next;
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
            dec_reg      <= dec_next;
            active_reg   <= active_next;
        end
    end

    // On a loaded circle the last step can leave x at most one past y.
    a_x_not_past_y: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((RADIUS_BITS+1)'(offset_x_reg)
                        <= (RADIUS_BITS+1)'(offset_y_reg) + (RADIUS_BITS+1)'(1)))
        else $error("offset_x ran too far past offset_y");

endmodule

// ===== design/mcpg_queue.sv =====
// Short command queue between the front end and the point emitter.
// Depends on mcpg_pkg for the command type and depth.
module mcpg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mcpg_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output mcpg_pkg::cmd_t      head,
    output mcpg_pkg::q_status_t status
);
    import mcpg_pkg::*;

    cmd_t                 mem [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;

    assign head         = mem[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QPTR_BITS+1)'(QDEPTH));

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full))
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("pop from empty command queue");

endmodule

// ===== design/mcpg_back.sv =====
// Point emitter: walks each queued command and sends its points, one per cycle
// while out_ready allows, through a registered output stage. Depends on mcpg_pkg.
module mcpg_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcpg_pkg::cmd_t                      head,
    input  mcpg_pkg::q_status_t                 q_status,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mcpg_pkg::PIX_BITS-1:0] pixel_x,
    output logic signed [mcpg_pkg::PIX_BITS-1:0] pixel_y,
    output logic                                last_point,
    output logic                                done_res
);
    import mcpg_pkg::*;

    logic [PT_BITS-1:0]          cnt_reg, cnt_next;
    logic                        valid_reg, valid_next;
    logic signed [PIX_BITS-1:0]  px_reg, px_next;
    logic signed [PIX_BITS-1:0]  py_reg, py_next;
    logic                        last_reg, last_next;
    logic                        done_reg, done_next;

    logic                        advance;
    logic                        load;
    logic                        is_last;
    logic [PT_BITS-1:0]          k;
    logic [RADIUS_BITS-1:0]      u;
    logic [RADIUS_BITS-1:0]      v;
    logic                        neg_u;
    logic                        neg_v;
    logic signed [PIX_BITS-1:0]  cxe, cye, ue, ve;

    assign advance = !valid_reg || out_ready;
    assign load    = advance && !q_status.empty;
    assign pop     = load && is_last;

    // Which symmetric point this cycle produces.
    always_comb
    begin
        unique case (head.kind)
            CMD_AXIS:
            begin
                k       = {cnt_reg[1], 1'b0, cnt_reg[0]};
                is_last = (cnt_reg == PT_BITS'(3));
            end
            CMD_OCTANT:
            begin
                k       = cnt_reg;
                is_last = (cnt_reg == PT_BITS'(7));
            end
            default:
            begin
                k       = '0;
                is_last = 1'b1;
            end
        endcase
        if (k[2])
        begin
            u     = head.oy;
            v     = head.ox;
            neg_u = k[0];
            neg_v = k[1];
        end
        else
        begin
            u     = head.ox;
            v     = head.oy;
            neg_u = k[1];
            neg_v = k[0];
        end
        cxe = $signed({{(PIX_BITS-COORD_BITS){1'b0}}, head.cx});
        cye = $signed({{(PIX_BITS-COORD_BITS){1'b0}}, head.cy});
        ue  = $signed({{(PIX_BITS-RADIUS_BITS){1'b0}}, u});
        ve  = $signed({{(PIX_BITS-RADIUS_BITS){1'b0}}, v});
    end

    // Output stage and point counter.
    always_comb
    begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = is_last ? '0 : cnt_reg + PT_BITS'(1);
            last_next  = is_last;
            done_next  = (head.kind == CMD_DONE);
            if (head.kind == CMD_DONE)
            begin
                px_next = '0;
                py_next = '0;
            end
            else
            begin
                px_next = neg_u ? cxe - ue : cxe + ue;
                py_next = neg_v ? cye - ve : cye + ve;
            end
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign out_valid  = valid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign last_point = last_reg;
    assign done_res   = done_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && done_reg) |-> (last_reg && px_reg == '0 && py_reg == '0))
        else $error("done result not a lone zero point");

    a_counter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> (cnt_reg == '0))
        else $error("point counter busy with no queued command");

endmodule

// ===== design/midpoint_circle_point_generator.sv =====
// Midpoint circle point generator, top level.
// With the emitter idle, an accepted item is written to the command queue, then its
// first point is registered in the emitter's output stage, which drives the outputs.
// Throughput: one point per cycle through the single output stage of the emitter, while
// out_ready allows; a start item gives 4 points, a step item 8, a completed step 1.
// Reset clears the circle state, empties the command queue and clears the point counter and output valid flag.
module midpoint_circle_point_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [mcpg_pkg::COORD_BITS-1:0]     center_x,
    input  logic [mcpg_pkg::COORD_BITS-1:0]     center_y,
    input  logic [mcpg_pkg::RADIUS_BITS-1:0]    radius,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mcpg_pkg::PIX_BITS-1:0] pixel_x,
    output logic signed [mcpg_pkg::PIX_BITS-1:0] pixel_y,
    output logic                                last_point,
    output logic                                done_res
);
    import mcpg_pkg::*;

    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;
    q_status_t q_status;

    mcpg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mcpg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    mcpg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_point (last_point),
        .done_res   (done_res)
    );

endmodule
